FILE: src/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg: shared types and constants of the maze backtracker step block
// Action and direction codes, register indexes, port widths and the control
// structs that run between the sequencer and its memories.
// ----------------------------------------------------------------------------
package mbs_pkg;

    // Default grid bounds
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Field widths on the ports
    localparam int RND_W      = 16;
    localparam int ACT_W      = 3;
    localparam int POS_W      = 6;
    localparam int DEPTH_W    = 13;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int DIM_W      = 7;

    // Register reset values
    localparam logic [POS_W-1:0] RST_START = '0;
    localparam logic [DIM_W-1:0] RST_DIM   = 7'd64;

    // Opcodes
    localparam logic OP_STEP    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 2'd3;

    typedef enum logic [ACT_W-1:0] {
        ACT_CARVED       = 3'd0,
        ACT_BACKTRACK    = 3'd1,
        ACT_JUST_DONE    = 3'd2,
        ACT_ALREADY_DONE = 3'd3,
        ACT_RESTART      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef struct packed {
        action_t              action;
        logic [POS_W-1:0]     from_row;
        logic [POS_W-1:0]     from_col;
        logic [POS_W-1:0]     to_row;
        logic [POS_W-1:0]     to_col;
        dir_t                 carve_dir;
        logic                 done_res;
        logic [DEPTH_W-1:0]   stack_depth;
    } result_t;

    // Visited map commands
    typedef struct packed {
        logic rd_nb;    // read the rows above and below the top cell
        logic rd_cur;   // read the row of the top cell
        logic clr;      // clear one row, seeding the start cell
        logic mark;     // set the chosen neighbor in its row
        dir_t dir;      // which fetched row the mark modifies
    } vis_ctl_t;

    // Cell stack commands
    typedef struct packed {
        logic init;
        logic push;
        logic pop;
    } stk_ctl_t;

endpackage

FILE: src/maze_backtracker_step.sv
// ----------------------------------------------------------------------------
// maze_backtracker_step: depth-first maze carver, one step per item
// Sequencer around a row-wide visited map and a cell stack, with a one-item
// result register toward the output stream.
// ----------------------------------------------------------------------------
// Each input item is a carve step or a restart and yields exactly one result
// item. A carve step runs from acceptance through S_RDCUR to S_EVAL: the
// acceptance cycle reads the visited rows above and below the top cell,
// S_RDCUR reads the top cell's own row (the visited map has two read ports),
// and S_EVAL picks the neighbor and writes the map and the stack. A step on
// an empty stack or after the maze is finished is answered from S_IDLE. A
// restart clears the visited map in S_CLEAR one row per cycle, seeding the
// start cell as it passes. After reset the same clearing pass runs before
// the first item is taken; configuration writes are taken at any time.
// Dimensions and start cell are sampled at reset and at each restart, so
// register writes take effect at the next restart. The result register lets
// the next item enter while a result still waits on m_tready.
// ----------------------------------------------------------------------------
module maze_backtracker_step
    import mbs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [RND_W-1:0]      s_tdata,    // [15:0] random_value
    input  logic                  s_tuser,    // [0] opcode

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [5:0] from_row, [11:6] from_col,
                                              // [17:12] to_row, [23:18] to_col,
                                              // [25:24] carve_dir, [26] done_res,
                                              // [39:27] stack_depth
    output logic [ACT_W-1:0]      m_tuser,    // [2:0] action

    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int ARW   = $clog2(MAX_ROWS + 1);
    localparam int ACW   = $clog2(MAX_COLS + 1);
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int SPW   = $clog2(CELLS + 1);

    // Grid size in use right after reset
    localparam int RST_ROWS = (int'(RST_DIM) > MAX_ROWS) ? MAX_ROWS : int'(RST_DIM);
    localparam int RST_COLS = (int'(RST_DIM) > MAX_COLS) ? MAX_COLS : int'(RST_DIM);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RDCUR = 4'b0100,
        S_EVAL  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;

    // Configuration registers
    logic [POS_W-1:0]  org_row_reg, org_row_next;
    logic [POS_W-1:0]  org_col_reg, org_col_next;
    logic [DIM_W-1:0]  rows_reg, rows_next;
    logic [DIM_W-1:0]  cols_reg, cols_next;

    // Values sampled at restart
    logic [ARW-1:0]    act_rows_reg, act_rows_next;
    logic [ACW-1:0]    act_cols_reg, act_cols_next;
    logic [RW-1:0]     st_row_reg, st_row_next;
    logic [CW-1:0]     st_col_reg, st_col_next;

    logic [RW-1:0]     clr_row_reg, clr_row_next;
    logic              finished_reg, finished_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;

    // Pending result and output register
    result_t           res_reg;
    result_t           res_new;
    logic              res_set;
    logic              res_pend_reg, res_pend_next;
    result_t           out_reg;
    logic              out_valid_reg, out_valid_next;

    logic              in_fire;
    logic              cfg_fire;
    logic              out_free;
    logic              xfer;
    logic              carve;

    logic [ARW-1:0]    new_rows;
    logic [ACW-1:0]    new_cols;
    logic [RW-1:0]     new_sr;
    logic [CW-1:0]     new_sc;

    vis_ctl_t          vis_ctl;
    stk_ctl_t          stk_ctl;
    logic [MAX_COLS-1:0] up_word;
    logic [MAX_COLS-1:0] dn_word;
    logic [MAX_COLS-1:0] cur_word;
    logic [RW-1:0]     top_row;
    logic [CW-1:0]     top_col;
    logic [SPW-1:0]    sp;

    logic              pick_found;
    dir_t              pick_dir;
    logic [RW-1:0]     pick_row;
    logic [CW-1:0]     pick_col;

    // Fit grid positions and depth into the fixed port fields
    logic [RW+POS_W-1:0]    new_sr_x, top_row_x, pick_row_x;
    logic [CW+POS_W-1:0]    new_sc_x, top_col_x, pick_col_x;
    logic [SPW+DEPTH_W-1:0] sp_x, sp_inc_x, sp_dec_x;

    assign new_sr_x   = {{POS_W{1'b0}}, new_sr};
    assign new_sc_x   = {{POS_W{1'b0}}, new_sc};
    assign top_row_x  = {{POS_W{1'b0}}, top_row};
    assign top_col_x  = {{POS_W{1'b0}}, top_col};
    assign pick_row_x = {{POS_W{1'b0}}, pick_row};
    assign pick_col_x = {{POS_W{1'b0}}, pick_col};
    assign sp_x       = {{DEPTH_W{1'b0}}, sp};
    assign sp_inc_x   = {{DEPTH_W{1'b0}}, SPW'(sp + SPW'(1))};
    assign sp_dec_x   = {{DEPTH_W{1'b0}}, SPW'(sp - SPW'(1))};

    // Handshakes: take an item only in idle, and only when the pending
    // result can move to the output register this cycle
    assign out_free  = !out_valid_reg || m_tready;
    assign xfer      = res_pend_reg && out_free;
    assign s_tready  = (state_reg == S_IDLE) && (!res_pend_reg || out_free);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Clamp grid size and start cell from the registers
    always_comb
    begin
        if (rows_reg == '0)
            new_rows = ARW'(1);
        else if (32'(rows_reg) > MAX_ROWS)
            new_rows = ARW'(MAX_ROWS);
        else
            new_rows = ARW'(rows_reg);

        if (cols_reg == '0)
            new_cols = ACW'(1);
        else if (32'(cols_reg) > MAX_COLS)
            new_cols = ACW'(MAX_COLS);
        else
            new_cols = ACW'(cols_reg);

        new_sr = (32'(org_row_reg) < 32'(new_rows)) ?
                 RW'(org_row_reg) : RW'(new_rows - ARW'(1));
        new_sc = (32'(org_col_reg) < 32'(new_cols)) ?
                 CW'(org_col_reg) : CW'(new_cols - ACW'(1));
    end

    // Carve only while the stack has room; otherwise fall back to a pop
    assign carve = pick_found && (32'(sp) < CELLS);

    always_comb
    begin
        state_next     = state_reg;
        org_row_next   = org_row_reg;
        org_col_next   = org_col_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        act_rows_next  = act_rows_reg;
        act_cols_next  = act_cols_reg;
        st_row_next    = st_row_reg;
        st_col_next    = st_col_reg;
        clr_row_next   = clr_row_reg;
        finished_next  = finished_reg;
        rnd_next       = rnd_reg;
        vis_ctl        = '0;
        stk_ctl        = '0;
        res_set        = 1'b0;
        res_new        = '0;

        if (cfg_fire)
        begin
            case (cfg_index)
                CFG_ORG_ROW: org_row_next = cfg_data[POS_W-1:0];
                CFG_ORG_COL: org_col_next = cfg_data[POS_W-1:0];
                CFG_ROWS:    rows_next    = cfg_data;
                CFG_COLS:    cols_next    = cfg_data;
                default:     rows_next    = rows_reg;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the map; seed the stack on the first row
                vis_ctl.clr  = 1'b1;
                stk_ctl.init = (clr_row_reg == '0);
                if (32'(clr_row_reg) == (MAX_ROWS - 1))
                    state_next = S_IDLE;
                else
                    clr_row_next = clr_row_reg + RW'(1);
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    rnd_next = s_tdata;
                    if (s_tuser == OP_RESTART)
                    begin
                        // Result is known now; the sweep follows
                        act_rows_next        = new_rows;
                        act_cols_next        = new_cols;
                        st_row_next          = new_sr;
                        st_col_next          = new_sc;
                        finished_next        = 1'b0;
                        clr_row_next         = '0;
                        state_next           = S_CLEAR;
                        res_set              = 1'b1;
                        res_new.action       = ACT_RESTART;
                        res_new.from_row     = new_sr_x[POS_W-1:0];
                        res_new.from_col     = new_sc_x[POS_W-1:0];
                        res_new.stack_depth  = DEPTH_W'(1);
                    end
                    else if (finished_reg)
                    begin
                        res_set             = 1'b1;
                        res_new.action      = ACT_ALREADY_DONE;
                        res_new.done_res    = 1'b1;
                        res_new.stack_depth = sp_x[DEPTH_W-1:0];
                    end
                    else if (sp == '0)
                    begin
                        finished_next       = 1'b1;
                        res_set             = 1'b1;
                        res_new.action      = ACT_JUST_DONE;
                        res_new.done_res    = 1'b1;
                        res_new.stack_depth = sp_x[DEPTH_W-1:0];
                    end
                    else
                    begin
                        // Fetch rows above and below the top cell
                        vis_ctl.rd_nb = 1'b1;
                        state_next    = S_RDCUR;
                    end
                end
            end

            S_RDCUR:
            begin
                vis_ctl.rd_cur = 1'b1;
                state_next     = S_EVAL;
            end

            S_EVAL:
            begin
                res_set          = 1'b1;
                res_new.from_row = top_row_x[POS_W-1:0];
                res_new.from_col = top_col_x[POS_W-1:0];
                if (carve)
                begin
                    vis_ctl.mark        = 1'b1;
                    vis_ctl.dir         = pick_dir;
                    stk_ctl.push        = 1'b1;
                    res_new.action      = ACT_CARVED;
                    res_new.to_row      = pick_row_x[POS_W-1:0];
                    res_new.to_col      = pick_col_x[POS_W-1:0];
                    res_new.carve_dir   = pick_dir;
                    res_new.stack_depth = sp_inc_x[DEPTH_W-1:0];
                end
                else
                begin
                    stk_ctl.pop         = 1'b1;
                    res_new.action      = ACT_BACKTRACK;
                    res_new.stack_depth = sp_dec_x[DEPTH_W-1:0];
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A new result wins over the one leaving in the same cycle
        if (res_set)
            res_pend_next = 1'b1;
        else if (xfer)
            res_pend_next = 1'b0;
        else
            res_pend_next = res_pend_reg;

        if (xfer)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            org_row_reg   <= RST_START;
            org_col_reg   <= RST_START;
            rows_reg      <= RST_DIM;
            cols_reg      <= RST_DIM;
            act_rows_reg  <= ARW'(RST_ROWS);
            act_cols_reg  <= ACW'(RST_COLS);
            st_row_reg    <= '0;
            st_col_reg    <= '0;
            clr_row_reg   <= '0;
            finished_reg  <= 1'b0;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            org_row_reg   <= org_row_next;
            org_col_reg   <= org_col_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            act_rows_reg  <= act_rows_next;
            act_cols_reg  <= act_cols_next;
            st_row_reg    <= st_row_next;
            st_col_reg    <= st_col_next;
            clr_row_reg   <= clr_row_next;
            finished_reg  <= finished_next;
            res_pend_reg  <= res_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rnd_reg <= rnd_next;
        if (res_set)
            res_reg <= res_new;
        if (xfer)
            out_reg <= res_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.action;
    assign m_tdata  = {out_reg.stack_depth, out_reg.done_res, out_reg.carve_dir,
                       out_reg.to_col, out_reg.to_row,
                       out_reg.from_col, out_reg.from_row};

    mbs_visited #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_visited (
        .clk      (clk),
        .ctl      (vis_ctl),
        .rd_row   (top_row),
        .clr_row  (clr_row_reg),
        .seed_row (st_row_reg),
        .seed_col (st_col_reg),
        .mark_row (pick_row),
        .mark_col (pick_col),
        .up_word  (up_word),
        .dn_word  (dn_word),
        .cur_word (cur_word)
    );

    mbs_stack #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (stk_ctl),
        .init_row (st_row_reg),
        .init_col (st_col_reg),
        .push_row (pick_row),
        .push_col (pick_col),
        .top_row  (top_row),
        .top_col  (top_col),
        .sp       (sp)
    );

    mbs_pick #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_pick (
        .row      (top_row),
        .col      (top_col),
        .act_rows (act_rows_reg),
        .act_cols (act_cols_reg),
        .up_word  (up_word),
        .dn_word  (dn_word),
        .cur_word (cur_word),
        .rnd      (rnd_reg),
        .found    (pick_found),
        .dir      (pick_dir),
        .to_row   (pick_row),
        .to_col   (pick_col)
    );

endmodule

FILE: src/mbs_pick.sv
// ----------------------------------------------------------------------------
// mbs_pick: neighbor selection
// Finds the free neighbors of the top cell in the order up, down, left, right
// and picks one by scaling the random value with the free count.
// ----------------------------------------------------------------------------
module mbs_pick
    import mbs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic [$clog2(MAX_ROWS)-1:0]   row,
    input  logic [$clog2(MAX_COLS)-1:0]   col,
    input  logic [$clog2(MAX_ROWS+1)-1:0] act_rows,
    input  logic [$clog2(MAX_COLS+1)-1:0] act_cols,
    input  logic [MAX_COLS-1:0]           up_word,
    input  logic [MAX_COLS-1:0]           dn_word,
    input  logic [MAX_COLS-1:0]           cur_word,
    input  logic [RND_W-1:0]              rnd,
    output logic                          found,
    output dir_t                          dir,
    output logic [$clog2(MAX_ROWS)-1:0]   to_row,
    output logic [$clog2(MAX_COLS)-1:0]   to_col
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    logic [3:0]       free;
    logic [2:0]       cnt;
    logic [RND_W+2:0] prod;
    logic [1:0]       k;
    logic [1:0]       seen;
    logic             hit;
    logic [CW-1:0]    col_dn;
    logic [CW-1:0]    col_up;

    always_comb
    begin
        col_dn = col - CW'(1);
        col_up = col + CW'(1);

        free[0] = (row != '0) ? !up_word[col] : 1'b0;
        free[1] = ((32'(row) + 1) < 32'(act_rows)) ? !dn_word[col] : 1'b0;
        free[2] = (col != '0) ? !cur_word[col_dn] : 1'b0;
        free[3] = ((32'(col) + 1) < 32'(act_cols)) ? !cur_word[col_up] : 1'b0;

        cnt   = 3'(free[0]) + 3'(free[1]) + 3'(free[2]) + 3'(free[3]);
        found = (cnt != 3'd0);

        // (rnd * cnt) >> 16 is always below cnt
        prod = (RND_W+3)'(rnd) * (RND_W+3)'(cnt);
        k    = prod[RND_W+1:RND_W];

        seen = 2'd0;
        hit  = 1'b0;
        dir  = DIR_UP;
        for (int i = 0; i < 4; i++)
        begin
            if (free[i] && !hit)
            begin
                if (seen == k)
                begin
                    hit = 1'b1;
                    dir = dir_t'(2'(i));
                end
                seen = seen + 2'd1;
            end
        end

        to_row = row;
        to_col = col;
        case (dir)
            DIR_UP:    to_row = row - RW'(1);
            DIR_DOWN:  to_row = row + RW'(1);
            DIR_LEFT:  to_col = col_dn;
            DIR_RIGHT: to_col = col_up;
            default:   to_row = row;
        endcase
    end

endmodule

FILE: src/mbs_visited.sv
// ----------------------------------------------------------------------------
// mbs_visited: visited map
// One word per grid row, one bit per column. Two read ports fetch the rows
// around the top cell; the write port clears rows or sets one cell.
// ----------------------------------------------------------------------------
module mbs_visited
    import mbs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                        clk,
    input  vis_ctl_t                    ctl,
    input  logic [$clog2(MAX_ROWS)-1:0] rd_row,
    input  logic [$clog2(MAX_ROWS)-1:0] clr_row,
    input  logic [$clog2(MAX_ROWS)-1:0] seed_row,
    input  logic [$clog2(MAX_COLS)-1:0] seed_col,
    input  logic [$clog2(MAX_ROWS)-1:0] mark_row,
    input  logic [$clog2(MAX_COLS)-1:0] mark_col,
    output logic [MAX_COLS-1:0]         up_word,
    output logic [MAX_COLS-1:0]         dn_word,
    output logic [MAX_COLS-1:0]         cur_word
);

    localparam int                  RW      = $clog2(MAX_ROWS);
    localparam logic [MAX_COLS-1:0] ONE_BIT = MAX_COLS'(1);

    logic [MAX_COLS-1:0] mem_reg [MAX_ROWS];
    logic [MAX_COLS-1:0] up_reg;
    logic [MAX_COLS-1:0] dn_reg;
    logic [MAX_COLS-1:0] cur_reg;

    logic [RW-1:0]       addr_a;
    logic [RW-1:0]       addr_b;
    logic                wr_en;
    logic [RW-1:0]       wr_row;
    logic [MAX_COLS-1:0] base;
    logic [MAX_COLS-1:0] wr_data;

    always_comb
    begin
        addr_a = ctl.rd_nb ? (rd_row - RW'(1)) : rd_row;
        addr_b = rd_row + RW'(1);
        wr_en  = ctl.clr || ctl.mark;
        wr_row = ctl.clr ? clr_row : mark_row;

        // Modify the row that was fetched for the chosen neighbor
        case (ctl.dir)
            DIR_UP:   base = up_reg;
            DIR_DOWN: base = dn_reg;
            default:  base = cur_reg;
        endcase

        if (ctl.clr)
            wr_data = (clr_row == seed_row) ? (ONE_BIT << seed_col) : '0;
        else
            wr_data = base | (ONE_BIT << mark_col);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_row] <= wr_data;
        if (ctl.rd_nb)
        begin
            up_reg <= mem_reg[addr_a];
            dn_reg <= mem_reg[addr_b];
        end
        if (ctl.rd_cur)
            cur_reg <= mem_reg[addr_a];
    end

    assign up_word  = up_reg;
    assign dn_word  = dn_reg;
    assign cur_word = cur_reg;

endmodule

FILE: src/mbs_stack.sv
// ----------------------------------------------------------------------------
// mbs_stack: cell stack
// Stack memory with its pointer. The top cell is held in a register after a
// push and taken from the registered read data after a pop.
// ----------------------------------------------------------------------------
module mbs_stack
    import mbs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  stk_ctl_t                                ctl,
    input  logic [$clog2(MAX_ROWS)-1:0]             init_row,
    input  logic [$clog2(MAX_COLS)-1:0]             init_col,
    input  logic [$clog2(MAX_ROWS)-1:0]             push_row,
    input  logic [$clog2(MAX_COLS)-1:0]             push_col,
    output logic [$clog2(MAX_ROWS)-1:0]             top_row,
    output logic [$clog2(MAX_COLS)-1:0]             top_col,
    output logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0]  sp
);

    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int CELL_W = RW + CW;
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(CELLS);
    localparam int SPW    = $clog2(CELLS + 1);

    logic [CELL_W-1:0] mem_reg [CELLS];
    logic [CELL_W-1:0] rd_reg;
    logic [CELL_W-1:0] top_reg;
    logic [CELL_W-1:0] top_next;
    logic [SPW-1:0]    sp_reg;
    logic [SPW-1:0]    sp_next;
    logic              use_rd_reg;
    logic              use_rd_next;
    logic [SPW-1:0]    sp_dec2;

    always_comb
    begin
        sp_dec2     = sp_reg - SPW'(2);
        sp_next     = sp_reg;
        top_next    = top_reg;
        use_rd_next = use_rd_reg;
        if (ctl.init)
        begin
            sp_next     = SPW'(1);
            top_next    = {init_row, init_col};
            use_rd_next = 1'b0;
        end
        else if (ctl.push)
        begin
            sp_next     = sp_reg + SPW'(1);
            top_next    = {push_row, push_col};
            use_rd_next = 1'b0;
        end
        else if (ctl.pop)
        begin
            sp_next     = sp_reg - SPW'(1);
            use_rd_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg     <= SPW'(1);
            top_reg    <= '0;
            use_rd_reg <= 1'b0;
        end
        else
        begin
            sp_reg     <= sp_next;
            top_reg    <= top_next;
            use_rd_reg <= use_rd_next;
        end
    end

    // Write the pushed cell, fetch the entry below the old top on a pop
    always_ff @(posedge clk)
    begin
        if (ctl.init)
            mem_reg[0] <= {init_row, init_col};
        else if (ctl.push)
            mem_reg[sp_reg[AW-1:0]] <= {push_row, push_col};
        if (ctl.pop)
            rd_reg <= mem_reg[sp_dec2[AW-1:0]];
    end

    assign {top_row, top_col} = use_rd_reg ? rd_reg : top_reg;
    assign sp                 = sp_reg;

endmodule

FILE: tb/maze_backtracker_step_tb.sv
// ----------------------------------------------------------------------------
// maze_backtracker_step_tb: self-checking bench for the maze backtracker step
// Drives restart and carve items through the input stream, predicts every
// result with a behavioral carver of its own and compares it field by field
// against the result stream, over several grid settings and idling patterns.
// ----------------------------------------------------------------------------
module maze_backtracker_step_tb;
    import mbs_pkg::*;

    localparam int GRID_MAX_ROWS = 64;
    localparam int GRID_MAX_COLS = 64;
    localparam int GRID_CELLS    = GRID_MAX_ROWS * GRID_MAX_COLS;
    localparam int QUIET_LIMIT   = 4000;  // cycles with no accepted item of any kind
    localparam int HOLD_LEN      = 200;   // long receiver hold-off, in cycles
    localparam int SETTLE_CYCLES = 80;    // lets a restart's clearing pass finish
    localparam int MODE_ITEMS    = 250;
    localparam int MAX_REPORTS   = 100;

    typedef struct packed {
        logic             op;
        logic [RND_W-1:0] rnd;
    } step_item_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [RND_W-1:0]      s_tdata   = '0;
    logic                  s_tuser   = OP_STEP;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [ACT_W-1:0]      m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    maze_backtracker_step DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Carver state as the bench sees it
    // ------------------------------------------------------------------------
    logic [POS_W-1:0] reg_org_row;
    logic [POS_W-1:0] reg_org_col;
    logic [DIM_W-1:0] reg_rows;
    logic [DIM_W-1:0] reg_cols;

    bit               seen_cell [0:GRID_CELLS-1];
    logic [11:0]      trail [0:GRID_CELLS-1];   // {row, col} of each stacked cell
    int unsigned      trail_len;
    bit               maze_done;
    int unsigned      grid_rows;                // dimensions latched at restart
    int unsigned      grid_cols;

    step_item_t       pending_steps [$];        // items waiting for the driver
    result_t          carve_expect [$];         // predicted results, oldest first

    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               hold_req       = 0;       // bumped to request a long hold-off
    int               hold_ack       = 0;
    int               hold_left      = 0;
    int               quiet_cycles   = 0;
    int               mismatch_count = 0;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned top);
        if (v < 1)
            return 1;
        if (v > top)
            return top;
        return 32'(v);
    endfunction

    // Latch the dimensions, clear the visited map and seed it with the start cell
    function automatic void restart_maze();
        logic [POS_W-1:0] r;
        logic [POS_W-1:0] c;
        grid_rows = clamp_dim(reg_rows, GRID_MAX_ROWS);
        grid_cols = clamp_dim(reg_cols, GRID_MAX_COLS);
        r = (reg_org_row < grid_rows) ? reg_org_row : POS_W'(grid_rows - 1);
        c = (reg_org_col < grid_cols) ? reg_org_col : POS_W'(grid_cols - 1);
        foreach (seen_cell[i])
            seen_cell[i] = 1'b0;
        seen_cell[r * GRID_MAX_COLS + c] = 1'b1;
        trail[0]  = {r, c};
        trail_len = 1;
        maze_done = 1'b0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_ORG_ROW: reg_org_row = value[POS_W-1:0];
            CFG_ORG_COL: reg_org_col = value[POS_W-1:0];
            CFG_ROWS:    reg_rows    = value;
            CFG_COLS:    reg_cols    = value;
            default: ;
        endcase
    endfunction

    // One carve step or restart; advances the bench state and returns the result
    function automatic result_t carve_predict(input logic op, input logic [RND_W-1:0] rnd);
        result_t     res;
        int unsigned cand_r [4];
        int unsigned cand_c [4];
        dir_t        cand_d [4];
        int unsigned n;
        int unsigned r;
        int unsigned c;
        int unsigned k;
        res = '0;
        n   = 0;
        if (op == OP_RESTART)
        begin
            restart_maze();
            res.action   = ACT_RESTART;
            res.from_row = trail[0][11:6];
            res.from_col = trail[0][5:0];
        end
        else if (maze_done)
            res.action = ACT_ALREADY_DONE;
        else if (trail_len == 0)
        begin
            maze_done  = 1'b1;
            res.action = ACT_JUST_DONE;
        end
        else
        begin
            r = 32'(trail[trail_len - 1][11:6]);
            c = 32'(trail[trail_len - 1][5:0]);
            res.from_row = POS_W'(r);
            res.from_col = POS_W'(c);
            // gather free neighbors: up, down, left, right
            if (r > 0 && !seen_cell[(r - 1) * GRID_MAX_COLS + c])
            begin
                cand_r[n] = r - 1; cand_c[n] = c; cand_d[n] = DIR_UP; n++;
            end
            if (r + 1 < grid_rows && !seen_cell[(r + 1) * GRID_MAX_COLS + c])
            begin
                cand_r[n] = r + 1; cand_c[n] = c; cand_d[n] = DIR_DOWN; n++;
            end
            if (c > 0 && !seen_cell[r * GRID_MAX_COLS + c - 1])
            begin
                cand_r[n] = r; cand_c[n] = c - 1; cand_d[n] = DIR_LEFT; n++;
            end
            if (c + 1 < grid_cols && !seen_cell[r * GRID_MAX_COLS + c + 1])
            begin
                cand_r[n] = r; cand_c[n] = c + 1; cand_d[n] = DIR_RIGHT; n++;
            end
            if (n > 0 && trail_len < GRID_CELLS)
            begin
                k = (int'(rnd) * n) >> 16;
                if (k >= n)
                    k = n - 1;
                res.action    = ACT_CARVED;
                res.to_row    = POS_W'(cand_r[k]);
                res.to_col    = POS_W'(cand_c[k]);
                res.carve_dir = cand_d[k];
                seen_cell[cand_r[k] * GRID_MAX_COLS + cand_c[k]] = 1'b1;
                trail[trail_len] = {res.to_row, res.to_col};
                trail_len++;
            end
            else
            begin
                trail_len--;
                res.action = ACT_BACKTRACK;
            end
        end
        res.done_res    = maze_done;
        res.stack_depth = trail_len[DEPTH_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: predict on acceptance, then offer the next pending item
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : item_driver
        step_item_t nxt;
        result_t    exp_res;
        if (s_tvalid && s_tready)
        begin
            exp_res      = carve_predict(s_tuser, s_tdata);
            carve_expect = {carve_expect, exp_res};
        end
        if (!s_tvalid || s_tready)
        begin
            if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_steps.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.rnd;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each accepted result, then decide next tready.
    // A long hold-off is counted here so the block fills and stalls its input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (m_tvalid && m_tready)
        begin
            if (carve_expect.size() == 0)
                report_mismatch("result with nothing expected", 16'(m_tuser), 16'(0));
            else
            begin
                want = carve_expect.pop_front();
                if (m_tuser !== want.action)
                    report_mismatch("action", 16'(m_tuser), 16'(want.action));
                if (m_tdata[5:0] !== want.from_row)
                    report_mismatch("from_row", 16'(m_tdata[5:0]), 16'(want.from_row));
                if (m_tdata[11:6] !== want.from_col)
                    report_mismatch("from_col", 16'(m_tdata[11:6]), 16'(want.from_col));
                if (m_tdata[17:12] !== want.to_row)
                    report_mismatch("to_row", 16'(m_tdata[17:12]), 16'(want.to_row));
                if (m_tdata[23:18] !== want.to_col)
                    report_mismatch("to_col", 16'(m_tdata[23:18]), 16'(want.to_col));
                if (m_tdata[25:24] !== want.carve_dir)
                    report_mismatch("carve_dir", 16'(m_tdata[25:24]), 16'(want.carve_dir));
                if (m_tdata[26] !== want.done_res)
                    report_mismatch("done_res", 16'(m_tdata[26]), 16'(want.done_res));
                if (m_tdata[39:27] !== want.stack_depth)
                    report_mismatch("stack_depth", 16'(m_tdata[39:27]),
                                    16'(want.stack_depth));
            end
        end
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Count cycles in which nothing at all is accepted
    always @(posedge clk)
    begin : quiet_counter
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_item(input logic op, input logic [RND_W-1:0] rnd);
        step_item_t it;
        it.op  = op;
        it.rnd = rnd;
        pending_steps = {pending_steps, it};
    endtask

    // Hold one register write until the channel takes it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg_write(idx, value);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item is taken and every result is back, then let a
    // possible restart clearing pass finish
    task automatic drain_block();
        while (pending_steps.size() != 0 || s_tvalid || carve_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(19))
            0:       return 7'd0;
            1:       return 7'd64;
            2:       return 7'd127;
            3:       return DIM_W'($urandom_range(127));
            4, 5:    return DIM_W'($urandom_range(16, 7));
            default: return DIM_W'($urandom_range(6, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        int               mode_items;
        int               seg;
        int unsigned      cells;
        int unsigned      n_steps;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;

        reg_org_row = RST_START;
        reg_org_col = RST_START;
        reg_rows    = RST_DIM;
        reg_cols    = RST_DIM;
        restart_maze();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset state on the full grid, random value extremes
        queue_item(OP_STEP, 16'h0000);
        queue_item(OP_STEP, 16'hFFFF);
        queue_item(OP_STEP, 16'h8000);
        queue_item(OP_STEP, 16'h5555);
        queue_item(OP_STEP, 16'hAAAA);
        queue_item(OP_STEP, 16'h0000);
        queue_item(OP_RESTART, 16'hFFFF);
        queue_item(OP_STEP, 16'h0001);
        drain_block();

        // Start cell beyond a 1x1 grid clamps to the corner; the old grid
        // holds until the restart. Then backtrack, finish and stay finished.
        write_reg(CFG_ORG_ROW, 7'd127);
        write_reg(CFG_ORG_COL, 7'd63);
        write_reg(CFG_ROWS, 7'd1);
        write_reg(CFG_COLS, 7'd1);
        queue_item(OP_STEP, 16'hFFFF);
        queue_item(OP_RESTART, 16'h0000);
        queue_item(OP_STEP, 16'h0000);
        queue_item(OP_STEP, 16'hFFFF);
        queue_item(OP_STEP, 16'h1234);
        drain_block();

        // Zero rows act as one, oversized columns act as the maximum
        write_reg(CFG_ROWS, 7'd0);
        write_reg(CFG_COLS, 7'd127);
        queue_item(OP_RESTART, 16'h0000);
        queue_item(OP_STEP, 16'h0000);
        queue_item(OP_STEP, 16'hFFFF);
        queue_item(OP_STEP, 16'h7FFF);
        drain_block();

        // Random: four idling modes, each a run of mostly restart-led carve sequences
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1:       begin send_idle_pct <= 58; recv_stall_pct <= 0;  end
                2:       begin send_idle_pct <= 0;  recv_stall_pct <= 58; end
                default: begin send_idle_pct <= 21; recv_stall_pct <= 21; end
            endcase
            mode_items = 0;
            seg        = 0;
            while (mode_items < MODE_ITEMS)
            begin
                rows = pick_dim();
                cols = pick_dim();
                if (mode == 0 && seg == 0)
                begin
                    rows = 7'd16;
                    cols = 7'd16;
                end
                write_reg(CFG_ORG_ROW, CFG_DATA_W'($urandom_range(127)));
                write_reg(CFG_ORG_COL, CFG_DATA_W'($urandom_range(127)));
                write_reg(CFG_ROWS, rows);
                write_reg(CFG_COLS, cols);

                // Hold the receiver off while the sender keeps offering items
                if (mode == 0 && seg == 0)
                begin
                    hold_req <= hold_req + 1;
                    @(posedge clk);
                end

                cells   = clamp_dim(rows, GRID_MAX_ROWS) * clamp_dim(cols, GRID_MAX_COLS);
                n_steps = 2 * cells + 3;
                if (n_steps > 160)
                    n_steps = 160;
                // Mostly a clean restart then steps; sometimes carry on from
                // the previous maze, and drop in a stray restart now and then
                if ($urandom_range(19) != 0)
                begin
                    queue_item(OP_RESTART, RND_W'($urandom));
                    mode_items++;
                end
                for (int i = 0; i < n_steps; i++)
                begin
                    queue_item(($urandom_range(39) == 0) ? OP_RESTART : OP_STEP,
                               RND_W'($urandom));
                    mode_items++;
                end
                // Sender pauses here until every result is back
                drain_block();
                seg++;
            end
        end

        drain_block();
        while (carve_expect.size() != 0)
        begin
            void'(carve_expect.pop_front());
            report_mismatch("result never delivered", 16'(0), 16'(0));
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: maze_backtracker_step.f
src/mbs_pkg.sv
src/mbs_pick.sv
src/mbs_visited.sv
src/mbs_stack.sv
src/maze_backtracker_step.sv
tb/maze_backtracker_step_tb.sv
